// File: src/c8vm_pkg.sv
package c8vm_pkg;

    localparam int MEM_DEPTH_DEF     = 4096;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_BEEP    = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [15:0] PC_RESET  = 16'h0200;
    localparam int          FONT_SIZE = 80;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] f;
        f = 8'h00;
        case (idx)
            7'd0: f = 8'hF0;   7'd1: f = 8'h90;   7'd2: f = 8'h90;   7'd3: f = 8'h90;
            7'd4: f = 8'hF0;   7'd5: f = 8'h20;   7'd6: f = 8'h60;   7'd7: f = 8'h20;
            7'd8: f = 8'h20;   7'd9: f = 8'h70;   7'd10: f = 8'hF0;  7'd11: f = 8'h10;
            7'd12: f = 8'hF0;  7'd13: f = 8'h80;  7'd14: f = 8'hF0;  7'd15: f = 8'hF0;
            7'd16: f = 8'h10;  7'd17: f = 8'hF0;  7'd18: f = 8'h10;  7'd19: f = 8'hF0;
            7'd20: f = 8'h90;  7'd21: f = 8'h90;  7'd22: f = 8'hF0;  7'd23: f = 8'h10;
            7'd24: f = 8'h10;  7'd25: f = 8'hF0;  7'd26: f = 8'h80;  7'd27: f = 8'hF0;
            7'd28: f = 8'h10;  7'd29: f = 8'hF0;  7'd30: f = 8'hF0;  7'd31: f = 8'h80;
            7'd32: f = 8'hF0;  7'd33: f = 8'h90;  7'd34: f = 8'hF0;  7'd35: f = 8'hF0;
            7'd36: f = 8'h10;  7'd37: f = 8'h20;  7'd38: f = 8'h40;  7'd39: f = 8'h40;
            7'd40: f = 8'hF0;  7'd41: f = 8'h90;  7'd42: f = 8'hF0;  7'd43: f = 8'h90;
            7'd44: f = 8'hF0;  7'd45: f = 8'hF0;  7'd46: f = 8'h90;  7'd47: f = 8'hF0;
            7'd48: f = 8'h10;  7'd49: f = 8'hF0;  7'd50: f = 8'hF0;  7'd51: f = 8'h90;
            7'd52: f = 8'hF0;  7'd53: f = 8'h90;  7'd54: f = 8'h90;  7'd55: f = 8'hE0;
            7'd56: f = 8'h90;  7'd57: f = 8'hE0;  7'd58: f = 8'h90;  7'd59: f = 8'hE0;
            7'd60: f = 8'hF0;  7'd61: f = 8'h80;  7'd62: f = 8'h80;  7'd63: f = 8'h80;
            7'd64: f = 8'hF0;  7'd65: f = 8'hE0;  7'd66: f = 8'h90;  7'd67: f = 8'h90;
            7'd68: f = 8'h90;  7'd69: f = 8'hE0;  7'd70: f = 8'hF0;  7'd71: f = 8'h80;
            7'd72: f = 8'hF0;  7'd73: f = 8'h80;  7'd74: f = 8'hF0;  7'd75: f = 8'hF0;
            7'd76: f = 8'h80;  7'd77: f = 8'hF0;  7'd78: f = 8'h80;  7'd79: f = 8'h80;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    // bcd digits of a byte by constant compares
    function automatic logic [11:0] bcd8(input logic [7:0] v);
        logic [7:0] r;
        logic [3:0] h;
        logic [3:0] t;
        h = 4'd0;
        r = v;
        if (r >= 8'd200) begin r = r - 8'd200; h = 4'd2; end
        else if (r >= 8'd100) begin r = r - 8'd100; h = 4'd1; end
        t = 4'd0;
        if (r >= 8'd50) begin r = r - 8'd50; t = 4'd5; end
        if (r >= 8'd30) begin r = r - 8'd30; t = t + 4'd3; end
        if (r >= 8'd20) begin r = r - 8'd20; t = t + 4'd2; end
        if (r >= 8'd10) begin r = r - 8'd10; t = t + 4'd1; end
        return {h, t, r[3:0]};
    endfunction

endpackage

// File: src/bytecode_vm_cpu_core.sv
// channel   direction  transfer marked by       payload
// command   in         start high, busy low     func address data keys random_byte
// result    out        done high for one cycle  status row_pixels draw_done pc_now
//
// a write item goes straight to its result, a display read first reads the row, and a
// step fetches, reads two registers and executes first; the byte memory, the register
// file and the display rows each take one read and one write a cycle, so draw walks
// each sprite row through the states DRWA, DRWB and DRWC, block store/load one byte
// per cycle and clear screen 32 rows; after reset the memory is filled with the font
// and zeros in one pass over all 4096 addresses while busy is high; results cannot be stalled
module bytecode_vm_cpu_core #(
    parameter int MEM_DEPTH     = c8vm_pkg::MEM_DEPTH_DEF,
    parameter int STACK_DEPTH   = c8vm_pkg::STACK_DEPTH_DEF,
    parameter int SCREEN_WIDTH  = c8vm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = c8vm_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  func,
    input  logic [11:0] address,
    input  logic [7:0]  data,
    input  logic [15:0] keys,
    input  logic [7:0]  random_byte,
    output logic [1:0]  status,
    output logic [SCREEN_WIDTH-1:0] row_pixels,
    output logic        draw_done,
    output logic [15:0] pc_now
);
    import c8vm_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int CW = $clog2(SCREEN_WIDTH);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_FET0   = 5'd2;
    localparam logic [4:0] S_FET1   = 5'd3;
    localparam logic [4:0] S_FET2   = 5'd4;
    localparam logic [4:0] S_REGRD  = 5'd5;
    localparam logic [4:0] S_EXEC   = 5'd6;
    localparam logic [4:0] S_CLR    = 5'd7;
    localparam logic [4:0] S_DRWA   = 5'd8;
    localparam logic [4:0] S_DRWB   = 5'd9;
    localparam logic [4:0] S_DRWC   = 5'd10;
    localparam logic [4:0] S_BCD    = 5'd11;
    localparam logic [4:0] S_STRA   = 5'd12;
    localparam logic [4:0] S_STRB   = 5'd13;
    localparam logic [4:0] S_LDA    = 5'd14;
    localparam logic [4:0] S_LDB    = 5'd15;
    localparam logic [4:0] S_RDROW  = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;
    localparam logic [4:0] S_RET    = 5'd18;

    logic [7:0]              mem [MEM_DEPTH];
    logic [7:0]              regs [16];
    logic [SCREEN_WIDTH-1:0] disp [SCREEN_HEIGHT];
    logic [15:0]             stk [STACK_DEPTH];

    logic [4:0]  state_reg, state_next;
    logic [AW:0] init_reg, init_next;

    logic        m_we;
    logic [AW-1:0] m_wa, m_ra;
    logic [7:0]  m_wd, m_rd;

    logic        r_we;
    logic [3:0]  r_wa, r_ra;
    logic [7:0]  r_wd, r_rd;

    logic        d_we;
    logic [RW-1:0] d_wa, d_ra;
    logic [SCREEN_WIDTH-1:0] d_wd, d_rd;

    logic        s_we;
    logic [SW-1:0] s_a;
    logic [15:0] s_rd;

    logic [15:0] pc_reg, pc_next, idx_reg, idx_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [SW-1:0] sp_dec;
    logic [7:0]  dly_reg, dly_next, snd_reg, snd_next;
    logic        dflag_reg, dflag_next;
    logic [15:0] op_reg, op_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  st_reg, st_next;
    logic        hit_reg, hit_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [1:0]  fn_reg, fn_next;
    logic [11:0] ad_reg, ad_next;
    logic [7:0]  dt_reg, dt_next;
    logic [11:0] bcd_reg, bcd_next;
    logic [SCREEN_WIDTH-1:0] row_reg, row_next;
    logic        done_reg, done_next;

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem[m_wa] <= m_wd;
        m_rd <= mem[m_ra];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
            regs[r_wa] <= r_wd;
        r_rd <= regs[r_ra];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            disp[d_wa] <= d_wd;
        d_rd <= disp[d_ra];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            stk[s_a] <= pc_reg;
        s_rd <= stk[s_a];
    end

    logic [3:0]  x_f, y_f, n_f;
    logic [7:0]  nn_f;
    logic [15:0] pc2, pc4;
    logic [SCREEN_WIDTH-1:0] spr;
    logic [3:0]  hikey;

    assign x_f  = op_reg[11:8];
    assign y_f  = op_reg[7:4];
    assign n_f  = op_reg[3:0];
    assign nn_f = op_reg[7:0];
    assign pc2  = pc_reg + 16'd2;
    assign pc4  = pc_reg + 16'd4;
    assign sp_dec = (sp_reg == '0) ? SW'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    always_comb
    begin
        logic [2*SCREEN_WIDTH-1:0] dbl;
        dbl = {m_rd, {(SCREEN_WIDTH-8){1'b0}}, m_rd, {(SCREEN_WIDTH-8){1'b0}}};
        dbl = dbl >> vx_reg[CW-1:0];
        spr = dbl[SCREEN_WIDTH-1:0];
    end

    always_comb
    begin
        hikey = 4'd0;
        for (int k = 0; k < 16; k++)
            if (keys_reg[k])
                hikey = k[3:0];
    end

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        sp_next    = sp_reg;
        dly_next   = dly_reg;
        snd_next   = snd_reg;
        dflag_next = dflag_reg;
        op_next    = op_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        hit_next   = hit_reg;
        keys_next  = keys_reg;
        rnd_next   = rnd_reg;
        fn_next    = fn_reg;
        ad_next    = ad_reg;
        dt_next    = dt_reg;
        bcd_next   = bcd_reg;
        row_next   = row_reg;
        done_next  = 1'b0;
        m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = pc_reg[AW-1:0];
        r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = x_f;
        d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
        s_we = 1'b0; s_a = sp_reg;

        unique case (state_reg)
            S_INIT:
            begin
                m_we = 1'b1;
                m_wa = init_reg[AW-1:0];
                m_wd = (init_reg < (AW+1)'(FONT_SIZE)) ? font_byte(init_reg[6:0]) : 8'h00;
                r_we = (init_reg < (AW+1)'(16));
                r_wa = init_reg[3:0];
                d_we = (init_reg < (AW+1)'(SCREEN_HEIGHT));
                d_wa = init_reg[RW-1:0];
                init_next = init_reg + 1'b1;
                if (init_reg == (AW+1)'(MEM_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    fn_next = func; ad_next = address; dt_next = data;
                    keys_next = keys; rnd_next = random_byte;
                    st_next = ST_NONE; row_next = '0;
                    unique case (func)
                        FUNC_WRITE: state_next = S_FIN;
                        FUNC_STEP:
                        begin
                            dflag_next = 1'b0;
                            state_next = S_FET0;
                        end
                        FUNC_READ:  state_next = S_RDROW;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_RDROW:
            begin
                d_ra = ad_reg[RW-1:0];
                state_next = S_RET;
            end
            S_RET:
            begin
                if (ad_reg < 12'(SCREEN_HEIGHT))
                    row_next = d_rd;
                state_next = S_FIN;
            end
            S_FET0:
            begin
                m_ra = pc_reg[AW-1:0];
                state_next = S_FET1;
            end
            S_FET1:
            begin
                m_ra = AW'(pc_reg + 16'd1);
                op_next[15:8] = m_rd;
                state_next = S_FET2;
            end
            S_FET2:
            begin
                op_next[7:0] = m_rd;
                r_ra = m_rd[7:4];
                s_a = sp_dec;
                state_next = S_REGRD;
            end
            S_REGRD:
            begin
                vy_next = r_rd;
                r_ra = x_f;
                s_a = sp_dec;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                vx_next = r_rd;
                pc_next = pc2;
                state_next = S_FIN;
                unique case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00E0)
                        begin
                            st_next = ST_CLEARED;
                            cnt_next = '0;
                            ad_next = '0;
                            state_next = S_CLR;
                        end
                        else if (op_reg == 16'h00EE)
                        begin
                            sp_next = sp_dec;
                            pc_next = s_rd + 16'd2;
                        end
                        else
                            st_next = ST_UNKNOWN;
                    end
                    4'h1: pc_next = {4'h0, op_reg[11:0]};
                    4'h2:
                    begin
                        s_we = 1'b1;
                        s_a = sp_reg;
                        sp_next = (sp_reg == SW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
                        pc_next = {4'h0, op_reg[11:0]};
                    end
                    4'h3: if (r_rd == nn_f) pc_next = pc4;
                    4'h4: if (r_rd != nn_f) pc_next = pc4;
                    4'h5: if (r_rd == vy_reg) pc_next = pc4;
                    4'h6: begin r_we = 1'b1; r_wa = x_f; r_wd = nn_f; end
                    4'h7: begin r_we = 1'b1; r_wa = x_f; r_wd = r_rd + nn_f; end
                    4'h8:
                    begin
                        logic [8:0] s;
                        s = {1'b0, r_rd} + {1'b0, vy_reg};
                        r_we = 1'b1; r_wa = x_f;
                        hit_next = 1'b0;
                        case (n_f)
                            4'h0: r_wd = vy_reg;
                            4'h1: r_wd = r_rd | vy_reg;
                            4'h2: r_wd = r_rd & vy_reg;
                            4'h3: r_wd = r_rd ^ vy_reg;
                            4'h4: begin r_wd = s[7:0]; hit_next = s[8]; end
                            4'h5: begin r_wd = r_rd - vy_reg; hit_next = (r_rd >= vy_reg); end
                            4'h6: begin r_wd = {1'b0, r_rd[7:1]}; hit_next = r_rd[0]; end
                            4'h7: begin r_wd = vy_reg - r_rd; hit_next = (vy_reg >= r_rd); end
                            4'hE: begin r_wd = {r_rd[6:0], 1'b0}; hit_next = r_rd[7]; end
                            default: begin r_we = 1'b0; st_next = ST_UNKNOWN; end
                        endcase
                        if (n_f == 4'h4 || n_f == 4'h5 || n_f == 4'h6 || n_f == 4'h7
                            || n_f == 4'hE)
                        begin
                            cnt_next = 4'hF;
                            state_next = S_LDB;
                            ad_next = 12'hFFF;
                        end
                    end
                    4'h9: if (r_rd != vy_reg) pc_next = pc4;
                    4'hA: idx_next = {4'h0, op_reg[11:0]};
                    4'hB:
                    begin
                        cnt_next = 4'd0;
                        state_next = S_DRWA;
                        ad_next = 12'hFFE;
                    end
                    4'hC: begin r_we = 1'b1; r_wa = x_f; r_wd = nn_f & rnd_reg; end
                    4'hD:
                    begin
                        dflag_next = 1'b1;
                        hit_next = 1'b0;
                        cnt_next = '0;
                        ad_next = '0;
                        state_next = S_DRWA;
                    end
                    4'hE:
                    begin
                        if (nn_f == 8'h9E)
                        begin
                            if (keys_reg[r_rd[3:0]]) pc_next = pc4;
                        end
                        else if (nn_f == 8'hA1)
                        begin
                            if (!keys_reg[r_rd[3:0]]) pc_next = pc4;
                        end
                        else
                            st_next = ST_UNKNOWN;
                    end
                    default:
                    begin
                        case (nn_f)
                            8'h07: begin r_we = 1'b1; r_wa = x_f; r_wd = dly_reg; end
                            8'h0A:
                            begin
                                if (keys_reg == 16'd0)
                                    pc_next = pc_reg;
                                else
                                begin
                                    r_we = 1'b1; r_wa = x_f; r_wd = {4'd0, hikey};
                                end
                            end
                            8'h15: dly_next = r_rd;
                            8'h18: snd_next = r_rd;
                            8'h1E:
                            begin
                                logic [16:0] s2;
                                s2 = {1'b0, idx_reg} + {9'd0, r_rd};
                                idx_next = s2[15:0];
                                r_we = 1'b1; r_wa = 4'hF;
                                r_wd = {7'd0, (s2 > 17'h00FFF)};
                            end
                            8'h29: idx_next = {10'd0, r_rd[3:0], 2'b00} + {12'd0, r_rd[3:0]};
                            8'h33:
                            begin
                                bcd_next = bcd8(r_rd);
                                cnt_next = '0;
                                state_next = S_BCD;
                            end
                            8'h55:
                            begin
                                cnt_next = '0;
                                r_ra = 4'd0;
                                state_next = S_STRA;
                            end
                            8'h65:
                            begin
                                cnt_next = '0;
                                ad_next = '0;
                                m_ra = idx_reg[AW-1:0];
                                state_next = S_LDA;
                            end
                            default: st_next = ST_UNKNOWN;
                        endcase
                    end
                endcase
            end
            S_CLR:
            begin
                d_we = 1'b1;
                d_wa = ad_reg[RW-1:0];
                ad_next = ad_reg + 12'd1;
                if (ad_reg == 12'(SCREEN_HEIGHT - 1))
                    state_next = S_FIN;
            end
            S_DRWA:
            begin
                if (ad_reg == 12'hFFE)
                begin
                    // jump with offset: v0 read
                    r_ra = 4'd0;
                    ad_next = 12'hFFD;
                end
                else if (ad_reg == 12'hFFD)
                begin
                    pc_next = {4'h0, op_reg[11:0]} + {8'd0, r_rd};
                    state_next = S_FIN;
                end
                else if (cnt_reg == n_f)
                begin
                    r_we = 1'b1; r_wa = 4'hF; r_wd = {7'd0, hit_reg};
                    state_next = S_FIN;
                end
                else
                begin
                    m_ra = AW'(idx_reg + {12'd0, cnt_reg});
                    d_ra = RW'(vy_reg + {4'd0, cnt_reg});
                    state_next = S_DRWB;
                end
            end
            S_DRWB:
            begin
                state_next = S_DRWC;
                m_ra = AW'(idx_reg + {12'd0, cnt_reg});
                d_ra = RW'(vy_reg + {4'd0, cnt_reg});
            end
            S_DRWC:
            begin
                d_we = 1'b1;
                d_wa = RW'(vy_reg + {4'd0, cnt_reg});
                d_wd = d_rd ^ spr;
                if ((d_rd & spr) != '0)
                    hit_next = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                state_next = S_DRWA;
            end
            S_LDB:
            begin
                // flag write after alu result
                r_we = 1'b1; r_wa = 4'hF; r_wd = {7'd0, hit_reg};
                state_next = S_FIN;
            end
            S_BCD:
            begin
                m_we = 1'b1;
                m_wa = AW'(idx_reg + {14'd0, cnt_reg[1:0]});
                m_wd = (cnt_reg == 4'd0) ? {4'd0, bcd_reg[11:8]} :
                       (cnt_reg == 4'd1) ? {4'd0, bcd_reg[7:4]} : {4'd0, bcd_reg[3:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd2)
                    state_next = S_FIN;
            end
            S_STRA:
            begin
                r_ra = cnt_reg;
                state_next = S_STRB;
            end
            S_STRB:
            begin
                m_we = 1'b1;
                m_wa = AW'(idx_reg + {12'd0, cnt_reg});
                m_wd = r_rd;
                cnt_next = cnt_reg + 1'b1;
                r_ra = cnt_reg + 1'b1;
                if (cnt_reg == x_f)
                begin
                    idx_next = idx_reg + {12'd0, x_f} + 16'd1;
                    state_next = S_FIN;
                end
            end
            S_LDA:
            begin
                m_ra = AW'(idx_reg + {12'd0, cnt_reg});
                if (ad_reg == 12'hFFC)
                begin
                    r_we = 1'b1; r_wa = cnt_reg - 1'b1; r_wd = m_rd;
                end
                ad_next = 12'hFFC;
                if (cnt_reg == x_f + 4'd1 && ad_reg == 12'hFFC && x_f != 4'hF)
                begin
                    idx_next = idx_reg + {12'd0, x_f} + 16'd1;
                    state_next = S_FIN;
                end
                else if (ad_reg == 12'hFFC && cnt_reg == 4'd0)
                begin
                    // x is f and all sixteen written
                    idx_next = idx_reg + 16'd16;
                    state_next = S_FIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_FIN:
            begin
                if (fn_reg == FUNC_WRITE)
                begin
                    m_we = 1'b1;
                    m_wa = ad_reg[AW-1:0];
                    m_wd = dt_reg;
                end
                if (fn_reg == FUNC_STEP)
                begin
                    if (dly_next != 8'd0)
                        dly_next = dly_next - 8'd1;
                    if (snd_next != 8'd0)
                    begin
                        if (snd_next == 8'd1)
                            st_next = ST_BEEP;
                        snd_next = snd_next - 8'd1;
                    end
                end
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            pc_reg    <= PC_RESET;
            idx_reg   <= '0;
            sp_reg    <= '0;
            dly_reg   <= '0;
            snd_reg   <= '0;
            dflag_reg <= 1'b0;
            done_reg  <= 1'b0;
            fn_reg    <= FUNC_WRITE;
            ad_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            dly_reg   <= dly_next;
            snd_reg   <= snd_next;
            dflag_reg <= dflag_next;
            done_reg  <= done_next;
            fn_reg    <= fn_next;
            ad_reg    <= ad_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        st_reg   <= st_next;
        hit_reg  <= hit_next;
        keys_reg <= keys_next;
        rnd_reg  <= rnd_next;
        dt_reg   <= dt_next;
        bcd_reg  <= bcd_next;
        row_reg  <= row_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = st_reg;
    assign row_pixels = row_reg;
    assign draw_done  = dflag_reg;
    assign pc_now     = pc_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result without return to idle");
    a_start_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer not taken");
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");
    a_rows_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && fn_reg != FUNC_READ |-> row_pixels == '0)
        else $error("row data on non-read item");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import c8vm_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] row;
        logic        drawn;
        logic [15:0] pc;
    } core_result_t;

    class core_scoreboard;
        logic [7:0]   mem [4096];
        logic [7:0]   v [16];
        logic [15:0]  ir;
        logic [15:0]  pc;
        logic [15:0]  rstack [16];
        bit           rstack_set [16];
        logic [3:0]   sp;
        logic [63:0]  disp [32];
        logic [7:0]   delay_t;
        logic [7:0]   sound_t;
        logic         drawn;
        core_result_t pending [$];
        int           errors;

        function void init();
            logic [7:0] glyph [80];
            glyph = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
                      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
                      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
                      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
                      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
                      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
                      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
                      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
            for (int i = 0; i < 4096; i++)
                mem[i] = (i < 80) ? glyph[i] : 8'h00;
            for (int i = 0; i < 16; i++)
            begin
                v[i] = 8'h00;
                rstack[i] = 16'h0000;
                rstack_set[i] = 0;
            end
            for (int i = 0; i < 32; i++)
                disp[i] = 64'h0;
            ir = 16'h0000;
            pc = PC_RESET;
            sp = 4'd0;
            delay_t = 8'h00;
            sound_t = 8'h00;
            drawn = 0;
            errors = 0;
        endfunction

        function logic [7:0] rd(logic [15:0] a);
            return mem[a[11:0]];
        endfunction

        function logic [15:0] fetch();
            logic [15:0] p1;
            p1 = pc + 16'd1;
            return {rd(pc), rd(p1)};
        endfunction

        // true when the next step would pop a return entry never pushed
        function bit bad_return();
            logic [3:0] top;
            top = sp - 4'd1;
            return fetch() == 16'h00EE && !rstack_set[top];
        endfunction

        function logic [1:0] exec(logic [15:0] keys, logic [7:0] rnd);
            logic [15:0] op;
            logic [15:0] nxt;
            logic [15:0] sum;
            logic [3:0]  x;
            logic [3:0]  y;
            logic [3:0]  n;
            logic [7:0]  nn;
            logic [7:0]  a;
            logic [7:0]  b;
            logic [7:0]  f;
            logic [1:0]  st;
            logic [5:0]  cx;
            logic [4:0]  cy;
            logic [4:0]  rowi;
            logic [63:0] m;
            logic        hit;
            op = fetch();
            x = op[11:8];
            y = op[7:4];
            n = op[3:0];
            nn = op[7:0];
            nxt = pc + 16'd2;
            st = ST_NONE;
            a = v[x];
            b = v[y];
            case (op[15:12])
                4'h0:
                begin
                    if (op == 16'h00E0)
                    begin
                        for (int i = 0; i < 32; i++)
                            disp[i] = 64'h0;
                        st = ST_CLEARED;
                    end
                    else if (op == 16'h00EE)
                    begin
                        sp = sp - 4'd1;
                        nxt = rstack[sp] + 16'd2;
                    end
                    else
                        st = ST_UNKNOWN;
                end
                4'h1: nxt = {4'h0, op[11:0]};
                4'h2:
                begin
                    rstack[sp] = pc;
                    rstack_set[sp] = 1;
                    sp = sp + 4'd1;
                    nxt = {4'h0, op[11:0]};
                end
                4'h3: if (a == nn) nxt = nxt + 16'd2;
                4'h4: if (a != nn) nxt = nxt + 16'd2;
                4'h5: if (a == b) nxt = nxt + 16'd2;
                4'h6: v[x] = nn;
                4'h7: v[x] = a + nn;
                4'h8:
                begin
                    case (n)
                        4'h0: v[x] = b;
                        4'h1: v[x] = a | b;
                        4'h2: v[x] = a & b;
                        4'h3: v[x] = a ^ b;
                        4'h4:
                        begin
                            sum = {8'h0, a} + {8'h0, b};
                            v[x] = sum[7:0];
                            v[15] = {7'h0, sum[8]};
                        end
                        4'h5:
                        begin
                            v[x] = a - b;
                            v[15] = {7'h0, a >= b};
                        end
                        4'h6:
                        begin
                            v[x] = a >> 1;
                            v[15] = {7'h0, a[0]};
                        end
                        4'h7:
                        begin
                            v[x] = b - a;
                            v[15] = {7'h0, b >= a};
                        end
                        4'hE:
                        begin
                            v[x] = a << 1;
                            v[15] = {7'h0, a[7]};
                        end
                        default: st = ST_UNKNOWN;
                    endcase
                end
                4'h9: if (a != b) nxt = nxt + 16'd2;
                4'hA: ir = {4'h0, op[11:0]};
                4'hB: nxt = {4'h0, op[11:0]} + {8'h0, v[0]};
                4'hC: v[x] = nn & rnd;
                4'hD:
                begin
                    cx = a[5:0];
                    cy = b[4:0];
                    hit = 0;
                    for (int r = 0; r < n; r++)
                    begin
                        m = {rd(ir + r[15:0]), 56'h0};
                        rowi = cy + r[4:0];
                        if (cx != 0)
                            m = (m >> cx) | (m << (7'd64 - cx));
                        if ((disp[rowi] & m) != 0)
                            hit = 1;
                        disp[rowi] = disp[rowi] ^ m;
                    end
                    v[15] = {7'h0, hit};
                    drawn = 1;
                end
                4'hE:
                begin
                    if (nn == 8'h9E)
                    begin
                        if (keys[a[3:0]]) nxt = nxt + 16'd2;
                    end
                    else if (nn == 8'hA1)
                    begin
                        if (!keys[a[3:0]]) nxt = nxt + 16'd2;
                    end
                    else
                        st = ST_UNKNOWN;
                end
                default:
                begin
                    case (nn)
                        8'h07: v[x] = delay_t;
                        8'h0A:
                        begin
                            if (keys == 16'h0)
                                nxt = pc;
                            else
                                for (int i = 0; i < 16; i++)
                                    if (keys[i]) v[x] = i[7:0];
                        end
                        8'h15: delay_t = a;
                        8'h18: sound_t = a;
                        8'h1E:
                        begin
                            v[15] = {7'h0, ({1'b0, ir} + {9'h0, a}) > 17'hFFF};
                            ir = ir + {8'h0, a};
                        end
                        8'h29: ir = {12'h0, a[3:0]} * 16'd5;
                        8'h33:
                        begin
                            mem[ir[11:0]] = a / 8'd100;
                            mem[ir[11:0] + 12'd1] = (a / 8'd10) % 8'd10;
                            mem[ir[11:0] + 12'd2] = a % 8'd10;
                        end
                        8'h55:
                        begin
                            for (int i = 0; i <= x; i++)
                                mem[ir[11:0] + i[11:0]] = v[i];
                            ir = ir + {12'h0, x} + 16'd1;
                        end
                        8'h65:
                        begin
                            for (int i = 0; i <= x; i++)
                                v[i] = mem[ir[11:0] + i[11:0]];
                            ir = ir + {12'h0, x} + 16'd1;
                        end
                        default: st = ST_UNKNOWN;
                    endcase
                end
            endcase
            pc = nxt;
            if (delay_t != 0)
                delay_t = delay_t - 8'd1;
            if (sound_t != 0)
            begin
                if (sound_t == 8'd1)
                    st = ST_BEEP;
                sound_t = sound_t - 8'd1;
            end
            return st;
        endfunction

        function void note(logic [1:0] fn, logic [11:0] addr, logic [7:0] dat,
                           logic [15:0] keys, logic [7:0] rnd);
            core_result_t e;
            e.status = ST_NONE;
            e.row = 64'h0;
            if (fn == FUNC_WRITE)
                mem[addr] = dat;
            else if (fn == FUNC_STEP)
            begin
                drawn = 0;
                e.status = exec(keys, rnd);
            end
            else if (fn == FUNC_READ && addr < 12'd32)
                e.row = disp[addr[4:0]];
            e.drawn = drawn;
            e.pc = pc;
            pending.push_back(e);
        endfunction

        function void check(logic [1:0] st, logic [63:0] row, logic dd, logic [15:0] pcv);
            core_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d pc=%h", $time, st, pcv);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (row !== e.row)
            begin
                $display("%0t: row_pixels expected %h actual %h", $time, e.row, row);
                errors++;
            end
            if (dd !== e.drawn)
            begin
                $display("%0t: draw_done expected %0d actual %0d", $time, e.drawn, dd);
                errors++;
            end
            if (pcv !== e.pc)
            begin
                $display("%0t: pc_now expected %h actual %h", $time, e.pc, pcv);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [1:0]  func;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic [1:0]  status;
    logic [63:0] row_pixels;
    logic        draw_done;
    logic [15:0] pc_now;

    core_scoreboard sb;
    int             idle_pct;
    int             sent;

    bytecode_vm_cpu_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .func(func), .address(address), .data(data), .keys(keys),
        .random_byte(random_byte), .status(status), .row_pixels(row_pixels),
        .draw_done(draw_done), .pc_now(pc_now)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check(status, row_pixels, draw_done, pc_now);

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send(logic [1:0] fn, logic [11:0] addr, logic [7:0] dat,
                        logic [15:0] k, logic [7:0] rnd);
        int gap;
        start <= 1;
        func <= fn;
        address <= addr;
        data <= dat;
        keys <= k;
        random_byte <= rnd;
        do @(posedge clk); while (busy);
        sb.note(fn, addr, dat, k, rnd);
        sent++;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_keys();
        return ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
    endfunction

    task automatic step(logic [15:0] k);
        logic [15:0] p1;
        p1 = sb.pc + 16'd1;
        if (sb.bad_return())
            send(FUNC_WRITE, p1[11:0], 8'hE0, 16'h0, 8'h0);
        send(FUNC_STEP, 12'($urandom), 8'($urandom), k, 8'($urandom));
    endtask

    task automatic run_op(logic [15:0] op, logic [15:0] k);
        logic [15:0] p1;
        p1 = sb.pc + 16'd1;
        send(FUNC_WRITE, sb.pc[11:0], op[15:8], 16'($urandom), 8'($urandom));
        send(FUNC_WRITE, p1[11:0], op[7:0], 16'($urandom), 8'($urandom));
        step(k);
    endtask

    function automatic logic [15:0] rand_op();
        logic [15:0] op;
        logic [7:0]  fsel [10];
        fsel = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'hFF};
        op = 16'($urandom);
        case (op[15:12])
            4'h0:
                case ($urandom_range(3))
                    0: op = 16'h00E0;
                    1: op = 16'h00EE;
                    2: op = {4'h0, op[11:0]};
                    default: op = 16'h00E0;
                endcase
            4'hE: if ($urandom_range(3) != 0) op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
            4'hF:
            begin
                op[7:0] = fsel[$urandom_range(9)];
                if (op[7:0] == 8'hFF) op[7:0] = 8'($urandom);
            end
            default: ;
        endcase
        return op;
    endfunction

    initial
    begin
        logic [15:0] prog [];
        int sel;
        sb = new();
        sb.init();
        sent = 0;
        idle_pct = 34;
        rst_n = 0;
        start = 0;
        func = FUNC_WRITE;
        address = 12'h0;
        data = 8'h0;
        keys = 16'h0;
        random_byte = 8'h0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        prog = '{16'h60FF, 16'h6101, 16'h8014, 16'h8015, 16'h8017, 16'h80E6, 16'h801E,
                 16'h8F18, 16'h0123, 16'hE0A0, 16'hF0FF, 16'h2400, 16'h00EE, 16'hA000,
                 16'h603F, 16'h611F, 16'hD01F, 16'hD01F, 16'hD010, 16'h60C8, 16'hAFFE,
                 16'hF033, 16'hFF55, 16'hF265, 16'hFF1E, 16'h6002, 16'hF018, 16'hB0FF};
        foreach (prog[i])
            run_op(prog[i], 16'hFFFF);
        send(FUNC_READ, 12'd31, 8'h0, 16'h0, 8'h0);
        send(FUNC_READ, 12'd4095, 8'h0, 16'h0, 8'h0);
        run_op(16'hF00A, 16'h0);
        step(16'h8001);
        send(FUNC_READ, 12'd0, 8'h0, 16'h0, 8'h0);
        run_op(16'h00E0, 16'h0);
        send(2'd3, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 34 : (ph == 1) ? 67 : 0;
            while (sent < 130 + 440 * (ph + 1))
            begin
                sel = $urandom_range(99);
                if (sel < 60)
                    run_op(rand_op(), rand_keys());
                else if (sel < 80)
                    step(rand_keys());
                else if (sel < 88)
                    send(FUNC_READ, $urandom_range(7) == 0 ? 12'($urandom) : 12'($urandom_range(31)),
                         8'($urandom), 16'($urandom), 8'($urandom));
                else if (sel < 96)
                    send(FUNC_WRITE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
                else
                    send(2'd3, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
            end
        end
        start <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: filelist.f
src/c8vm_pkg.sv
src/bytecode_vm_cpu_core.sv
sim/tb.sv
